### hw/rtl/mtrr_pkg.sv
// mtrr_pkg: shared constants, codes, command/status structs and a helper
// function for the memory type resolver.
// No dependencies.
package mtrr_pkg;

  // Table and field geometry
  localparam int NUM_RANGES = 8;
  localparam int FRAME_W    = 36;
  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 31;
  localparam int TYPE_W     = 3;
  localparam int NUM_TYPES  = 1 << TYPE_W;
  localparam int RIDX_W     = 3;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_CNT_W = SIZE_W + 1 - PAGE_SHIFT;

  localparam logic [PAGE_SHIFT-1:0] PAGE_OFFSET_MASK = '1;
  localparam logic [FRAME_W-1:0]    LOW_MEG_FRAMES   = FRAME_W'(36'h100);

  // Memory type codes
  localparam logic [TYPE_W-1:0] TYPE_UC = '0;

  // Request kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MTRR_EN  = 2'd0,
    CFG_FIX_EN   = 2'd1,
    CFG_FIX_SUP  = 2'd2,
    CFG_DEF_TYPE = 2'd3
  } cfg_idx_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_query;
    logic write_range;
    logic step;
    logic load_result;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic skip;       // query needs no page walk (disabled or zero length)
    logic last_page;  // current page is the last one of the region
    logic page_uc;    // current page classifies as uncacheable
  } dp_status_t;

  // Smallest type code present in a type set; empty set gives uncacheable
  function automatic logic [TYPE_W-1:0] lowest_type(input logic [NUM_TYPES-1:0] set);
    logic [TYPE_W-1:0] res;
    res = TYPE_UC;
    for (int t = NUM_TYPES - 1; t >= 0; t--) begin
      if (set[t]) begin
        res = TYPE_W'(t);
      end
    end
    return res;
  endfunction

endpackage

### hw/rtl/mtrr_in_if.sv
// mtrr_in_if: request channel of the memory type resolver.
// Depends on mtrr_pkg.
interface mtrr_in_if
  import mtrr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [RIDX_W-1:0]    range_index;
  logic [FRAME_W-1:0]   range_base_frame;
  logic [FRAME_W-1:0]   range_mask_frame;
  logic [TYPE_W-1:0]    range_type;
  logic                 range_valid;
  logic [ADDR_W-1:0]    query_address;
  logic [SIZE_W-1:0]    query_size;

  modport source (
    output valid, action, range_index, range_base_frame, range_mask_frame,
           range_type, range_valid, query_address, query_size,
    input  ready
  );

  modport sink (
    input  valid, action, range_index, range_base_frame, range_mask_frame,
           range_type, range_valid, query_address, query_size,
    output ready
  );
endinterface

### hw/rtl/mtrr_out_if.sv
// mtrr_out_if: result channel of the memory type resolver.
// Depends on mtrr_pkg.
interface mtrr_out_if
  import mtrr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] memory_type;

  modport source (
    output valid, memory_type,
    input  ready
  );

  modport sink (
    input  valid, memory_type,
    output ready
  );
endinterface

### hw/rtl/mtrr_dp.sv
// mtrr_dp: datapath of the resolver: range table lanes, config registers,
// page walker (frame and page counters), per-page classifier and result reg.
// Depends on mtrr_pkg.
module mtrr_dp
  import mtrr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // config port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // request payload
  input  logic [RIDX_W-1:0]     range_index,
  input  logic [FRAME_W-1:0]    range_base_frame,
  input  logic [FRAME_W-1:0]    range_mask_frame,
  input  logic [TYPE_W-1:0]     range_type,
  input  logic                  range_valid,
  input  logic [ADDR_W-1:0]     query_address,
  input  logic [SIZE_W-1:0]     query_size,
  // control
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic [TYPE_W-1:0]     memory_type
);

  // Config registers
  logic              mtrr_en_r;
  logic              fix_en_r;
  logic              fix_sup_r;
  logic [TYPE_W-1:0] def_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtrr_en_r  <= 1'b0;
      fix_en_r   <= 1'b0;
      fix_sup_r  <= 1'b0;
      def_type_r <= TYPE_UC;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MTRR_EN:  mtrr_en_r  <= cfg_wdata[0];
        CFG_FIX_EN:   fix_en_r   <= cfg_wdata[0];
        CFG_FIX_SUP:  fix_sup_r  <= cfg_wdata[0];
        CFG_DEF_TYPE: def_type_r <= cfg_wdata[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Range table: one lane per descriptor, all compared in parallel
  logic [FRAME_W-1:0] base_r  [NUM_RANGES];
  logic [FRAME_W-1:0] mask_r  [NUM_RANGES];
  logic [TYPE_W-1:0]  type_r  [NUM_RANGES];
  logic [NUM_RANGES-1:0] valid_r;

  for (genvar r = 0; r < NUM_RANGES; r++) begin : g_lane
    logic lane_we;
    // slots past the table never decode, so such writes drop
    assign lane_we = cmd.write_range && (int'(range_index) == r);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[r] <= 1'b0;
      end else if (lane_we) begin
        valid_r[r] <= range_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (lane_we) begin
        base_r[r] <= range_base_frame;
        mask_r[r] <= range_mask_frame;
        type_r[r] <= range_type;
      end
    end
  end

  // Page walker state
  logic [FRAME_W-1:0]    frame_r, frame_nxt;
  logic [PAGE_CNT_W-1:0] pages_r, pages_nxt;
  logic [NUM_TYPES-1:0]  acc_r, acc_nxt;
  logic [TYPE_W-1:0]     memory_type_r, memory_type_nxt;

  // Page count of the request: size rounded up to whole pages
  logic [SIZE_W:0]       size_rnd;
  logic [PAGE_CNT_W-1:0] req_pages;

  assign size_rnd  = {1'b0, query_size} + (SIZE_W + 1)'(PAGE_OFFSET_MASK);
  assign req_pages = size_rnd[SIZE_W:PAGE_SHIFT];

  // Classify the current page as a set of candidate type codes
  logic [NUM_RANGES-1:0] hit;
  logic [NUM_TYPES-1:0]  present;
  logic [NUM_TYPES-1:0]  page_set;
  logic                  low_meg;

  always_comb begin
    present = '0;
    for (int r = 0; r < NUM_RANGES; r++) begin
      hit[r] = valid_r[r] && (((frame_r ^ base_r[r]) & mask_r[r]) == '0);
      if (hit[r]) begin
        present = present | (NUM_TYPES'(1) << type_r[r]);
      end
    end
    low_meg = fix_sup_r && fix_en_r && (frame_r < LOW_MEG_FRAMES);
    if (low_meg) begin
      page_set = NUM_TYPES'(1) << TYPE_UC;
    end else if (|hit) begin
      page_set = present;
    end else begin
      page_set = NUM_TYPES'(1) << def_type_r;
    end
  end

  // Walker update
  always_comb begin
    frame_nxt       = frame_r;
    pages_nxt       = pages_r;
    acc_nxt         = acc_r;
    memory_type_nxt = memory_type_r;
    if (cmd.load_query) begin
      frame_nxt = query_address[ADDR_W-1:PAGE_SHIFT];
      pages_nxt = req_pages;
      acc_nxt   = '0;
    end else if (cmd.step) begin
      frame_nxt = frame_r + FRAME_W'(1);
      pages_nxt = pages_r - PAGE_CNT_W'(1);
      acc_nxt   = acc_r | page_set;
    end
    if (cmd.load_result) begin
      memory_type_nxt = lowest_type(acc_r);
    end
  end

  always_ff @(posedge clk) begin
    frame_r       <= frame_nxt;
    pages_r       <= pages_nxt;
    acc_r         <= acc_nxt;
    memory_type_r <= memory_type_nxt;
  end

  // Status to the controller
  assign status.skip      = !mtrr_en_r || (req_pages == '0);
  assign status.last_page = (pages_r == PAGE_CNT_W'(1));
  assign status.page_uc   = page_set[TYPE_UC];

  assign memory_type = memory_type_r;

endmodule

### hw/rtl/mtrr_ctrl.sv
// mtrr_ctrl: controller state machine of the resolver: request handshake,
// page walk sequencing and the result register's valid flag.
// Depends on mtrr_pkg.
module mtrr_ctrl
  import mtrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_action,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_QUERY) begin
            cmd.load_query = 1'b1;
            state_nxt      = status.skip ? S_FINISH : S_WALK;
          end else begin
            cmd.write_range = 1'b1;
          end
        end
      end
      S_WALK: begin
        // one page per cycle; an uncacheable page settles the result
        cmd.step = 1'b1;
        if (status.last_page || status.page_uc) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_result = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hw/rtl/mtrr_memory_type_resolver.sv
// Memory type resolver: holds NUM_RANGES variable range descriptors and
// resolves the memory type of a queried byte region page by page. A write
// request loads one descriptor and gives no result. A query walks its region
// in 4 KiB pages: every page is checked against all ranges at once by the
// single page classifier, and the walk stops early at the first uncacheable
// page. A zero-length query or one issued while typing is disabled skips the
// walk. The next request is taken once the result sits in the output
// register, even if it is not yet taken.
// Depends on mtrr_pkg, mtrr_in_if, mtrr_out_if, mtrr_ctrl and mtrr_dp.
module mtrr_memory_type_resolver
  import mtrr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mtrr_in_if.sink               in_ch,
  mtrr_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  mtrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Range table and page walker
  mtrr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .range_index      (in_ch.range_index),
    .range_base_frame (in_ch.range_base_frame),
    .range_mask_frame (in_ch.range_mask_frame),
    .range_type       (in_ch.range_type),
    .range_valid      (in_ch.range_valid),
    .query_address    (in_ch.query_address),
    .query_size       (in_ch.query_size),
    .cmd              (cmd),
    .status           (status),
    .memory_type      (out_ch.memory_type)
  );

  // A query occupies the block: no new request the cycle after it
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.action == ACT_QUERY) |=> !in_ch.ready)
    else $error("request taken right after a query");

  // A descriptor write never produces a result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.action == ACT_WRITE && !out_ch.valid)
      |=> !out_ch.valid)
    else $error("result raised by a descriptor write");

  // Query load, descriptor write, walk step and result load never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_query, cmd.write_range, cmd.step, cmd.load_result}))
    else $error("conflicting datapath commands");

endmodule

### test/mtrr_memory_type_resolver_tb.sv
// Testbench for mtrr_memory_type_resolver: range descriptor writes and region
// queries go through a request driver, results are checked against a built-in
// predictor of the range table. Depends on mtrr_pkg, mtrr_in_if and mtrr_out_if.
`timescale 1ns / 100ps

module mtrr_memory_type_resolver_tb;
  import mtrr_pkg::*;

  localparam int                 CYCLE_LIMIT = 10_000_000;
  localparam int                 PHASE_REQS  = 190;
  localparam logic [FRAME_W-1:0] FRAME_ONES  = '1;
  localparam logic [SIZE_W-1:0]  ONE_GIB     = SIZE_W'(32'h4000_0000);

  typedef struct {
    logic               act;
    logic [RIDX_W-1:0]  slot;
    logic [FRAME_W-1:0] base;
    logic [FRAME_W-1:0] mask;
    logic [TYPE_W-1:0]  kind;
    logic               live;
    logic [ADDR_W-1:0]  addr;
    logic [SIZE_W-1:0]  size;
  } mtrr_req_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mtrr_in_if  req_bus ();
  mtrr_out_if res_bus ();

  mtrr_memory_type_resolver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_bus),
    .out_ch    (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the descriptor table and registers
  logic [FRAME_W-1:0] slot_base [NUM_RANGES];
  logic [FRAME_W-1:0] slot_mask [NUM_RANGES];
  logic [TYPE_W-1:0]  slot_kind [NUM_RANGES];
  logic               slot_live [NUM_RANGES];
  logic               typing_on;
  logic               fixed_on;
  logic               fixed_present;
  logic [TYPE_W-1:0]  fallback_kind;

  mtrr_req_t         pending_reqs [$];
  logic [TYPE_W-1:0] expected_types [$];
  int                reqs_queued;
  int                reqs_taken;
  int                mismatches;
  int                cycle_count;
  logic              in_fire;
  bit                idle_on;
  int unsigned       src_gap;
  int unsigned       snk_gap;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Type of one page frame under the current table and registers
  function automatic logic [TYPE_W-1:0] classify_page(logic [FRAME_W-1:0] frame);
    logic [TYPE_W-1:0] lowest;
    bit                hit;
    lowest = TYPE_UC;
    hit    = 1'b0;
    if (!typing_on) return TYPE_UC;
    if (frame < LOW_MEG_FRAMES && fixed_present && fixed_on) return TYPE_UC;
    for (int r = 0; r < NUM_RANGES; r++) begin
      if (slot_live[r] && ((frame & slot_mask[r]) == (slot_base[r] & slot_mask[r]))) begin
        if (slot_kind[r] == TYPE_UC) return TYPE_UC;
        if (!hit || slot_kind[r] < lowest) lowest = slot_kind[r];
        hit = 1'b1;
      end
    end
    return hit ? lowest : fallback_kind;
  endfunction

  // Resolved type of a byte region; frames wrap at the top of the frame space
  function automatic logic [TYPE_W-1:0] resolve_region(logic [ADDR_W-1:0] addr,
                                                       logic [SIZE_W-1:0] size);
    logic [63:0]       first_frame;
    logic [63:0]       pages;
    logic [TYPE_W-1:0] lowest;
    logic [TYPE_W-1:0] t;
    bit                found;
    lowest      = TYPE_UC;
    found       = 1'b0;
    first_frame = 64'(addr >> PAGE_SHIFT);
    pages       = (64'(size) + 64'(PAGE_OFFSET_MASK)) >> PAGE_SHIFT;
    if (!typing_on) return TYPE_UC;
    for (longint unsigned i = 0; i < pages; i++) begin
      t = classify_page(FRAME_W'(first_frame + i));
      if (t == TYPE_UC) return TYPE_UC;
      if (!found || t < lowest) lowest = t;
      found = 1'b1;
    end
    return found ? lowest : TYPE_UC;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Register write, only issued while nothing is in flight
  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_MTRR_EN:  typing_on     = value[0];
      CFG_FIX_EN:   fixed_on      = value[0];
      CFG_FIX_SUP:  fixed_present = value[0];
      CFG_DEF_TYPE: fallback_kind = value[TYPE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic en, logic fen, logic sup, logic [TYPE_W-1:0] dflt);
    cfg_write(CFG_MTRR_EN, CFG_DATA_W'(en));
    cfg_write(CFG_FIX_EN, CFG_DATA_W'(fen));
    cfg_write(CFG_FIX_SUP, CFG_DATA_W'(sup));
    cfg_write(CFG_DEF_TYPE, CFG_DATA_W'(dflt));
  endtask

  // Wait until every request is taken and every result is back, then let
  // a trailing descriptor write settle
  task automatic wait_idle();
    while (reqs_taken != reqs_queued || expected_types.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic push_range(int slot, logic [FRAME_W-1:0] base, logic [FRAME_W-1:0] mask,
                            logic [TYPE_W-1:0] kind, logic live);
    mtrr_req_t r;
    r.act  = ACT_WRITE;
    r.slot = RIDX_W'(slot);
    r.base = base;
    r.mask = mask;
    r.kind = kind;
    r.live = live;
    r.addr = ADDR_W'({$urandom, $urandom});
    r.size = SIZE_W'($urandom);
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic push_query(logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] size);
    mtrr_req_t r;
    r.act  = ACT_QUERY;
    r.slot = RIDX_W'($urandom);
    r.base = FRAME_W'({$urandom, $urandom});
    r.mask = FRAME_W'({$urandom, $urandom});
    r.kind = TYPE_W'($urandom);
    r.live = 1'($urandom);
    r.addr = addr;
    r.size = size;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // Mostly aligned ranges and queries inside a 64 MiB window so that
  // matches, overlaps and the low megabyte are hit often; the rest is noise
  task automatic add_random_request(bit wide);
    int                 pick;
    int                 k;
    logic [FRAME_W-1:0] m;
    logic [SIZE_W-1:0]  sz;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      k = $urandom_range(0, 12);
      m = FRAME_ONES << k;
      push_range($urandom_range(0, NUM_RANGES - 1), FRAME_W'($urandom_range(0, 'h3FFF)) & m,
                 m, TYPE_W'($urandom_range(0, 7)), $urandom_range(0, 9) != 0);
    end else if (pick < 36) begin
      push_range($urandom_range(0, NUM_RANGES - 1), FRAME_W'({$urandom, $urandom}),
                 FRAME_W'({$urandom, $urandom}), TYPE_W'($urandom_range(0, 7)),
                 1'($urandom));
    end else begin
      k = $urandom_range(0, 19);
      if (k == 0) sz = '0;
      else if (k < 16) sz = SIZE_W'($urandom_range(1, 'h8000));
      else if (k < 19) sz = SIZE_W'($urandom_range(1, 'h40000));
      else sz = SIZE_W'($urandom_range(1, 'h200000));
      if (wide) sz = SIZE_W'($urandom_range(0, 1 << 30));
      if (pick < 92) begin
        push_query({FRAME_W'($urandom_range(0, 'h3FFF)), PAGE_SHIFT'($urandom)}, sz);
      end else begin
        push_query(ADDR_W'({$urandom, $urandom}), sz);
      end
    end
  endtask

  // Request driver: holds a request until taken, idles in random bursts
  always @(negedge clk) begin
    mtrr_req_t r;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || in_fire) begin
      if (src_gap > 0) begin
        req_bus.valid <= 1'b0;
        src_gap       <= src_gap - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        req_bus.valid <= 1'b0;
        src_gap       <= $urandom_range(0, 9);
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        req_bus.valid            <= 1'b1;
        req_bus.action           <= r.act;
        req_bus.range_index      <= r.slot;
        req_bus.range_base_frame <= r.base;
        req_bus.range_mask_frame <= r.mask;
        req_bus.range_type       <= r.kind;
        req_bus.range_valid      <= r.live;
        req_bus.query_address    <= r.addr;
        req_bus.query_size       <= r.size;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Result sink with random stall bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      res_bus.ready <= 1'b0;
      snk_gap       <= snk_gap - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res_bus.ready <= 1'b0;
      snk_gap       <= $urandom_range(0, 9);
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // Monitor: update predictor on taken requests, check taken results
  always @(posedge clk) begin
    logic [TYPE_W-1:0] want;
    in_fire <= rst_n && req_bus.valid === 1'b1 && req_bus.ready === 1'b1;
    if (rst_n) begin
      cycle_count++;
      if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
        reqs_taken++;
        if (req_bus.action == ACT_WRITE) begin
          if (req_bus.range_index < NUM_RANGES) begin
            slot_base[req_bus.range_index] = req_bus.range_base_frame;
            slot_mask[req_bus.range_index] = req_bus.range_mask_frame;
            slot_kind[req_bus.range_index] = req_bus.range_type;
            slot_live[req_bus.range_index] = req_bus.range_valid;
          end
        end else begin
          expected_types.push_back(resolve_region(req_bus.query_address,
                                                  req_bus.query_size));
        end
      end
      if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
        if (expected_types.size() == 0) begin
          report_mismatch($sformatf("memory_type %0d with no query pending",
                                    res_bus.memory_type));
        end else begin
          want = expected_types.pop_front();
          if (res_bus.memory_type !== want) begin
            report_mismatch($sformatf("memory_type got %0d want %0d",
                                      res_bus.memory_type, want));
          end
        end
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[mtrr_memory_type_resolver] ERROR");
        $finish;
      end
    end
  end

  // Stimulus and phase sequencing
  initial begin
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_index                = CFG_MTRR_EN;
    cfg_wdata                = '0;
    req_bus.valid            = 1'b0;
    req_bus.action           = ACT_WRITE;
    req_bus.range_index      = '0;
    req_bus.range_base_frame = '0;
    req_bus.range_mask_frame = '0;
    req_bus.range_type       = '0;
    req_bus.range_valid      = 1'b0;
    req_bus.query_address    = '0;
    req_bus.query_size       = '0;
    res_bus.ready            = 1'b0;
    in_fire                  = 1'b0;
    idle_on                  = 1'b1;
    src_gap                  = 0;
    snk_gap                  = 0;
    reqs_queued              = 0;
    reqs_taken               = 0;
    mismatches               = 0;
    cycle_count              = 0;
    typing_on                = 1'b0;
    fixed_on                 = 1'b0;
    fixed_present            = 1'b0;
    fallback_kind            = TYPE_UC;
    for (int r = 0; r < NUM_RANGES; r++) begin
      slot_base[r] = '0;
      slot_mask[r] = '0;
      slot_kind[r] = TYPE_UC;
      slot_live[r] = 1'b0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Typing disabled after reset: huge and empty regions, extreme descriptors
    push_query(FRAME_ONES == '1 ? '1 : '0, ONE_GIB);
    push_query('0, '0);
    push_range(NUM_RANGES - 1, FRAME_ONES, FRAME_ONES, 3'd7, 1'b1);
    push_range(0, '0, '0, TYPE_UC, 1'b0);
    wait_idle();

    // Typing on, fixed ranges on, default at top code
    set_config(1'b1, 1'b1, 1'b1, 3'd7);
    push_range(1, 36'h200, FRAME_ONES << 9, 3'd6, 1'b1);
    push_range(2, 36'h300, FRAME_ONES << 8, 3'd4, 1'b1);
    push_range(3, 36'h380, FRAME_ONES << 6, TYPE_UC, 1'b1);
    push_range(4, 36'h400, FRAME_ONES << 9, 3'd5, 1'b0);
    push_range(5, 36'h100000, FRAME_ONES << 12, 3'd1, 1'b1);
    push_query(48'h0, 31'h1000);             // low megabyte
    push_query(48'hFF000, 31'h2000);         // straddles the 1 MiB line
    push_query(48'h100000, 31'h1000);        // no match, default
    push_query(48'h200123, 31'hFFF);         // unaligned start, one page
    push_query(48'h2FF000, 31'h2000);        // overlap, lower code wins
    push_query(48'h37F000, 31'h3000);        // runs into an uncacheable range
    push_query(48'h400000, 31'h1001);        // invalid range ignored
    push_query(48'hFFFF_FFFF_F000, 31'h2000); // frame wraps to zero
    push_query(48'hFFFF_FFFF_FABC, 31'h1);   // top frame only
    push_query(48'h0, '0);                   // empty region
    push_query(48'h1_0000_0000, ONE_GIB);    // full-length walk
    wait_idle();

    // Fixed ranges off: low megabyte falls through to the ranges
    cfg_write(CFG_FIX_EN, '0);
    push_query(48'h0, 31'h1000);
    wait_idle();
    cfg_write(CFG_DEF_TYPE, CFG_DATA_W'(TYPE_UC));
    push_query(48'h0, 31'h1000);
    push_query(48'h200000, 31'h1000);
    wait_idle();

    // Random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(1'b1, 1'b0, 1'b0, TYPE_UC);
        1: set_config(1'b1, 1'b1, 1'b0, 3'd7);
        2: set_config(1'b0, 1'b1, 1'b1, TYPE_W'($urandom));
        3: set_config(1'b1, 1'b1, 1'b1, TYPE_W'($urandom_range(1, 6)));
        4: set_config(1'b1, 1'b0, 1'b1, TYPE_W'($urandom));
        default: set_config(1'b1, 1'($urandom), 1'($urandom), TYPE_W'($urandom));
      endcase
      idle_on = (p != 3 && p != 5);
      for (int i = 0; i < PHASE_REQS; i++) add_random_request(p == 2);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("[mtrr_memory_type_resolver] OK");
    end else begin
      $display("[mtrr_memory_type_resolver] ERROR");
    end
    $finish;
  end

endmodule
